[src/bounded_packet_fifo_with_dedup_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bounded packet FIFO with duplicate filter
// Shared wrappers that clock on clk and hold off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PACKET_FIFO_WITH_DEDUP_CORE_DEFINES_SVH
`define BOUNDED_PACKET_FIFO_WITH_DEDUP_CORE_DEFINES_SVH

// same-cycle implication
`define BPFD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPFD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bpfd_pkg.sv]
// ----------------------------------------------------------------------------
// bpfd_pkg
// Shared types and constants of the bounded packet FIFO with duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfd_pkg;

  // default sizes
  localparam int DEPTH_DEF        = 1024;
  localparam int NODE_ID_BITS_DEF = 16;
  localparam int TIME_BITS_DEF    = 32;

  // limit register and count result widths
  localparam int LIMIT_W = 11;
  localparam int CNT_W   = 11;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_FWD   = 2'd1,
    OP_COUNT = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FWD_RD,
    S_RESULT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture the item, arm the scan
    logic scan_rd;  // read next held entry
    logic fwd_rd;   // read oldest entry
    logic commit;   // update store and load result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic fill_zero;
    logic scan_last;
    logic pipe_empty;
  } sts_t;

endpackage

`default_nettype wire

[src/bpfd_ram.sv]
// ----------------------------------------------------------------------------
// bpfd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]             wdata,
  input  wire logic                         re,
  input  wire logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] raddr,
  output logic      [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, hold when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[src/bpfd_ctrl.sv]
// ----------------------------------------------------------------------------
// bpfd_ctrl
// Sequencer: takes one item at a time, runs the scan or the forward read,
// then commits and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfd_ctrl import bpfd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_operation,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  op_t    in_op;

  assign in_op  = op_t'(in_operation);
  assign in_acc = in_valid && !in_stall;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.load = 1'b1;
          if (in_op inside {OP_ADD, OP_COUNT}) begin
            state_nxt = sts.fill_zero ? S_RESULT : S_SCAN;
          end else if (in_op == OP_FWD) begin
            state_nxt = sts.fill_zero ? S_RESULT : S_FWD_RD;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = S_RESULT;
        end
      end
      S_FWD_RD: begin
        cmd.fwd_rd = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        // wait for a free output register
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // set on commit, clear when the result is taken
  assign out_valid_nxt = cmd.commit || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

endmodule

`default_nettype wire

[src/bpfd_dp.sv]
// ----------------------------------------------------------------------------
// bpfd_dp
// Datapath: ring store, pointers, fill level, limit register, the compare
// pipeline of the scan and the output payload registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfd_dp import bpfd_pkg::*; #(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int NODE_ID_BITS = NODE_ID_BITS_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cmd_t                    cmd,
  output sts_t                         sts,
  input  wire logic                    cfg_wr_en,
  input  wire logic [LIMIT_W-1:0]      cfg_wr_data,
  input  wire logic [1:0]              in_operation,
  input  wire logic [NODE_ID_BITS-1:0] in_source,
  input  wire logic [NODE_ID_BITS-1:0] in_destination,
  input  wire logic [TIME_BITS-1:0]    in_timestamp,
  input  wire logic [TIME_BITS-1:0]    in_start_time,
  input  wire logic [TIME_BITS-1:0]    in_end_time,
  output logic                         out_accepted,
  output logic                         out_valid_res,
  output logic [NODE_ID_BITS-1:0]      out_source,
  output logic [NODE_ID_BITS-1:0]      out_destination,
  output logic [TIME_BITS-1:0]         out_timestamp,
  output logic [CNT_W-1:0]             out_match_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int LW = (FW > LIMIT_W) ? FW : LIMIT_W;
  localparam int EW = 2 * NODE_ID_BITS + TIME_BITS;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [LW-1:0] DEPTH_L  = LW'(DEPTH);

  // control registers
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [AW-1:0]      oldest_r, oldest_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [AW-1:0]      scan_ptr_r, scan_ptr_nxt;
  logic [FW-1:0]      scan_cnt_r, scan_cnt_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               hit_vld_r, hit_vld_nxt;

  // item and scan payload registers
  op_t                   op_r, op_nxt;
  logic [NODE_ID_BITS-1:0] src_r, src_nxt;
  logic [NODE_ID_BITS-1:0] dst_r, dst_nxt;
  logic [TIME_BITS-1:0]  ts_r, ts_nxt;
  logic [TIME_BITS-1:0]  lo_r, lo_nxt;
  logic [TIME_BITS-1:0]  hi_r, hi_nxt;
  logic                  dup_hit_r, dup_hit_nxt;
  logic                  cnt_hit_r, cnt_hit_nxt;
  logic                  dup_r, dup_nxt;
  logic [CNT_W-1:0]      acc_r, acc_nxt;

  // result registers
  logic                    acc_ok_r, acc_ok_nxt;
  logic                    vres_r, vres_nxt;
  logic [NODE_ID_BITS-1:0] osrc_r, osrc_nxt;
  logic [NODE_ID_BITS-1:0] odst_r, odst_nxt;
  logic [TIME_BITS-1:0]    ots_r, ots_nxt;
  logic [CNT_W-1:0]        ocnt_r, ocnt_nxt;

  // store signals
  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [EW-1:0]           ram_wdata, ram_rdata;
  logic [NODE_ID_BITS-1:0] rd_src, rd_dst;
  logic [TIME_BITS-1:0]    rd_ts;
  logic [LW-1:0]           lim_ext, eff_limit;
  logic                    full;
  logic                    fill_zero;

  assign rd_src = ram_rdata[EW-1 -: NODE_ID_BITS];
  assign rd_dst = ram_rdata[TIME_BITS +: NODE_ID_BITS];
  assign rd_ts  = ram_rdata[TIME_BITS-1:0];

  // clamp the limit to 1..DEPTH
  always_comb begin
    lim_ext = LW'(limit_r);
    if (lim_ext == '0) begin
      eff_limit = LW'(1);
    end else if (lim_ext > DEPTH_L) begin
      eff_limit = DEPTH_L;
    end else begin
      eff_limit = lim_ext;
    end
  end

  assign full      = (LW'(fill_r) >= eff_limit);
  assign fill_zero = (fill_r == '0);

  // store ports
  assign ram_we    = cmd.commit && (op_r == OP_ADD) && !dup_r;
  assign ram_wdata = {src_r, dst_r, ts_r};
  assign ram_re    = cmd.scan_rd || cmd.fwd_rd;
  assign ram_raddr = cmd.scan_rd ? scan_ptr_r : oldest_r;

  bpfd_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // status to the controller
  assign sts.fill_zero  = fill_zero;
  assign sts.scan_last  = (scan_cnt_r == fill_r - FW'(1));
  assign sts.pipe_empty = !rd_vld_r && !hit_vld_r;

  // next values
  always_comb begin
    limit_nxt    = cfg_wr_en ? cfg_wr_data : limit_r;
    oldest_nxt   = oldest_r;
    tail_nxt     = tail_r;
    fill_nxt     = fill_r;
    scan_ptr_nxt = scan_ptr_r;
    scan_cnt_nxt = scan_cnt_r;
    op_nxt       = op_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    ts_nxt       = ts_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    dup_nxt      = dup_r;
    acc_nxt      = acc_r;
    acc_ok_nxt   = acc_ok_r;
    vres_nxt     = vres_r;
    osrc_nxt     = osrc_r;
    odst_nxt     = odst_r;
    ots_nxt      = ots_r;
    ocnt_nxt     = ocnt_r;

    // compare pipeline: read, compare, accumulate
    rd_vld_nxt  = cmd.scan_rd;
    hit_vld_nxt = rd_vld_r;
    dup_hit_nxt = (ram_rdata == {src_r, dst_r, ts_r});
    cnt_hit_nxt = (rd_dst == dst_r) && (rd_ts >= lo_r) && (rd_ts <= hi_r);

    if (cmd.load) begin
      op_nxt       = op_t'(in_operation);
      src_nxt      = in_source;
      dst_nxt      = in_destination;
      ts_nxt       = in_timestamp;
      lo_nxt       = in_start_time;
      hi_nxt       = in_end_time;
      scan_ptr_nxt = oldest_r;
      scan_cnt_nxt = '0;
      dup_nxt      = 1'b0;
      acc_nxt      = '0;
    end else if (hit_vld_r) begin
      dup_nxt = dup_r || dup_hit_r;
      acc_nxt = acc_r + CNT_W'(cnt_hit_r);
    end

    // advance the scan pointer with wrap
    if (cmd.scan_rd) begin
      scan_ptr_nxt = (scan_ptr_r == LAST_PTR) ? '0 : scan_ptr_r + AW'(1);
      scan_cnt_nxt = scan_cnt_r + FW'(1);
    end

    // commit: update the ring and load the result
    if (cmd.commit) begin
      acc_ok_nxt = 1'b0;
      vres_nxt   = 1'b0;
      osrc_nxt   = '0;
      odst_nxt   = '0;
      ots_nxt    = '0;
      ocnt_nxt   = '0;
      case (op_r)
        OP_ADD: begin
          if (!dup_r) begin
            acc_ok_nxt = 1'b1;
            tail_nxt   = (tail_r == LAST_PTR) ? '0 : tail_r + AW'(1);
            if (full) begin
              // drop oldest, fill level stays
              oldest_nxt = (oldest_r == LAST_PTR) ? '0 : oldest_r + AW'(1);
            end else begin
              fill_nxt = fill_r + FW'(1);
            end
          end
        end
        OP_FWD: begin
          if (!fill_zero) begin
            vres_nxt   = 1'b1;
            osrc_nxt   = rd_src;
            odst_nxt   = rd_dst;
            ots_nxt    = rd_ts;
            oldest_nxt = (oldest_r == LAST_PTR) ? '0 : oldest_r + AW'(1);
            fill_nxt   = fill_r - FW'(1);
          end
        end
        OP_COUNT: begin
          ocnt_nxt = acc_r;
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LIMIT_RESET;
      oldest_r  <= '0;
      tail_r    <= '0;
      fill_r    <= '0;
      rd_vld_r  <= 1'b0;
      hit_vld_r <= 1'b0;
    end else begin
      limit_r   <= limit_nxt;
      oldest_r  <= oldest_nxt;
      tail_r    <= tail_nxt;
      fill_r    <= fill_nxt;
      rd_vld_r  <= rd_vld_nxt;
      hit_vld_r <= hit_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_ptr_r <= scan_ptr_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    op_r       <= op_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    ts_r       <= ts_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    dup_hit_r  <= dup_hit_nxt;
    cnt_hit_r  <= cnt_hit_nxt;
    dup_r      <= dup_nxt;
    acc_r      <= acc_nxt;
    acc_ok_r   <= acc_ok_nxt;
    vres_r     <= vres_nxt;
    osrc_r     <= osrc_nxt;
    odst_r     <= odst_nxt;
    ots_r      <= ots_nxt;
    ocnt_r     <= ocnt_nxt;
  end

  assign out_accepted    = acc_ok_r;
  assign out_valid_res   = vres_r;
  assign out_source      = osrc_r;
  assign out_destination = odst_r;
  assign out_timestamp   = ots_r;
  assign out_match_count = ocnt_r;

endmodule

`default_nettype wire

[src/bounded_packet_fifo_with_dedup_core.sv]
// ----------------------------------------------------------------------------
// Bounded packet FIFO with duplicate filter
// Ring buffer of packets with duplicate rejection, forward and range count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one operation per item: add a
//   packet, forward the oldest packet, or count held packets that match a
//   destination and an inclusive time range. Each item yields exactly one
//   result item on the output channel (out_valid/out_stall).
//   cfg_wr_en/cfg_wr_data set the packet limit; write it only while idle.
//   Add and count scan every held entry, one store read per cycle, and
//   then wait for the compare pipeline to drain; forward reads the oldest
//   entry once. An empty forward, an unknown operation, or an add or count
//   on an empty store goes straight to the result.
//   The single read port of the store and the one-item-at-a-time sequencer
//   bound the throughput; with no output stall the next item is taken in the
//   cycle after the result is loaded.
//   in_stall is high from the cycle after an accept until the result sits in
//   the output register, so a new item can be taken while the previous
//   result still waits.
//   Reset empties the buffer and sets the limit to 1024; the store needs
//   no clearing pass. While out_stall is high the result is held and the
//   next finished item waits inside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_packet_fifo_with_dedup_core import bpfd_pkg::*; #(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int NODE_ID_BITS = NODE_ID_BITS_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_wr_en,
  input  wire logic [LIMIT_W-1:0]      cfg_wr_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              in_operation,
  input  wire logic [NODE_ID_BITS-1:0] in_source,
  input  wire logic [NODE_ID_BITS-1:0] in_destination,
  input  wire logic [TIME_BITS-1:0]    in_timestamp,
  input  wire logic [TIME_BITS-1:0]    in_start_time,
  input  wire logic [TIME_BITS-1:0]    in_end_time,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_accepted,
  output logic                         out_valid_res,
  output logic [NODE_ID_BITS-1:0]      out_source,
  output logic [NODE_ID_BITS-1:0]      out_destination,
  output logic [TIME_BITS-1:0]         out_timestamp,
  output logic [CNT_W-1:0]             out_match_count
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  bpfd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // store and arithmetic
  bpfd_dp #(
    .DEPTH        (DEPTH),
    .NODE_ID_BITS (NODE_ID_BITS),
    .TIME_BITS    (TIME_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_operation    (in_operation),
    .in_source       (in_source),
    .in_destination  (in_destination),
    .in_timestamp    (in_timestamp),
    .in_start_time   (in_start_time),
    .in_end_time     (in_end_time),
    .out_accepted    (out_accepted),
    .out_valid_res   (out_valid_res),
    .out_source      (out_source),
    .out_destination (out_destination),
    .out_timestamp   (out_timestamp),
    .out_match_count (out_match_count)
  );

endmodule

`default_nettype wire

[src/bpfd_checker.sv]
// ----------------------------------------------------------------------------
// bpfd_checker
// Port-level checks on the bounded packet FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_packet_fifo_with_dedup_core_defines.svh"

module bpfd_checker import bpfd_pkg::*; #(
  parameter int NODE_ID_BITS = NODE_ID_BITS_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic                    out_accepted,
  input wire logic                    out_valid_res,
  input wire logic [NODE_ID_BITS-1:0] out_source,
  input wire logic [NODE_ID_BITS-1:0] out_destination,
  input wire logic [TIME_BITS-1:0]    out_timestamp,
  input wire logic [CNT_W-1:0]        out_match_count
);

  // one item in work: busy right after an accept
  `BPFD_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept not followed by stall")

  // a stalled result holds
  `BPFD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_match_count) && $stable(out_accepted) && $stable(out_timestamp), "stalled result changed")

  // at most one kind of result field is set
  `BPFD_ASSERT_IMP(a_one_kind, out_valid, !(out_accepted && out_valid_res) && !(out_accepted && (out_match_count != '0)) && !(out_valid_res && (out_match_count != '0)), "result mixes operations")

  // packet fields are zero unless a packet was forwarded
  `BPFD_ASSERT_IMP(a_empty_fwd_zero, out_valid && !out_valid_res, (out_source == '0) && (out_destination == '0) && (out_timestamp == '0), "packet fields set without forward")

endmodule

bind bounded_packet_fifo_with_dedup_core bpfd_checker #(
  .NODE_ID_BITS (NODE_ID_BITS),
  .TIME_BITS    (TIME_BITS)
) u_bpfd_checker (.*);

`default_nettype wire

[sim/bounded_packet_fifo_with_dedup_core_tb.sv]
// ----------------------------------------------------------------------------
// Bounded packet FIFO with duplicate filter: self-checking testbench
// Directed rows from a table start the run; known rows carry typed-in results.
// Random phases follow, each after a limit write; a buffer model predicts
// the rest. Outside a calm phase both channels idle and stall at random.
// ----------------------------------------------------------------------------
module bounded_packet_fifo_with_dedup_core_tb import bpfd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NW            = NODE_ID_BITS_DEF;
  localparam int TW            = TIME_BITS_DEF;
  localparam int IDLE_PCT      = 21;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int STUCK_LIMIT   = 20000;
  localparam int NUM_DIRECTED  = 25;

  // one operation as presented on the input channel
  typedef struct {
    op_t           op;
    logic [NW-1:0] src;
    logic [NW-1:0] dst;
    logic [TW-1:0] ts;
    logic [TW-1:0] t_lo;
    logic [TW-1:0] t_hi;
  } packet_op_t;

  // one result item
  typedef struct {
    logic             accepted;
    logic             valid_res;
    logic [NW-1:0]    src;
    logic [NW-1:0]    dst;
    logic [TW-1:0]    ts;
    logic [CNT_W-1:0] count;
  } op_result_t;

  // one held packet
  typedef struct {
    logic [NW-1:0] src;
    logic [NW-1:0] dst;
    logic [TW-1:0] ts;
  } packet_t;

  // directed row; known rows carry a typed-in expectation
  typedef struct packed {
    op_t              op;
    logic [NW-1:0]    src;
    logic [NW-1:0]    dst;
    logic [TW-1:0]    ts;
    logic [TW-1:0]    t_lo;
    logic [TW-1:0]    t_hi;
    logic             known;
    logic             want_acc;
    logic [CNT_W-1:0] want_cnt;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
    '{OP_FWD,   16'h0000, 16'h0000, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 1'b0, 11'd0},
    '{OP_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 11'd0},
    '{OP_NOP,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b1, 1'b0, 11'd0},
    '{OP_ADD,   16'h0000, 16'h0000, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 1'b1, 11'd0},
    '{OP_ADD,   16'h0000, 16'h0000, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 1'b0, 11'd0},
    '{OP_ADD,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b1, 11'd0},
    '{OP_ADD,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b0, 11'd0},
    '{OP_ADD,   16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b1, 11'd0},
    '{OP_ADD,   16'hFFFF, 16'h0000, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 1'b1, 11'd0},
    '{OP_ADD,   16'h0000, 16'h0000, 32'h0000_0001, 32'h0, 32'h0, 1'b1, 1'b1, 11'd0},
    '{OP_ADD,   16'h0000, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b1, 1'b0, 11'd0},
    '{OP_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 11'd0},
    '{OP_COUNT, 16'h0000, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 11'd0},
    '{OP_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0, 11'd0},
    '{OP_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 11'd0},
    '{OP_COUNT, 16'h0000, 16'hFFFF, 32'h0, 32'h0000_0000, 32'hFFFF_FFFE, 1'b0, 1'b0, 11'd0},
    '{OP_NOP,   16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 11'd0},
    '{OP_FWD,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b0, 11'd0},
    '{OP_FWD,   16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 11'd0},
    '{OP_ADD,   16'h0000, 16'h0000, 32'h0000_0000, 32'h0, 32'h0, 1'b0, 1'b0, 11'd0},
    '{OP_FWD,   16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 11'd0},
    '{OP_FWD,   16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 11'd0},
    '{OP_FWD,   16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 11'd0},
    '{OP_FWD,   16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 11'd0},
    '{OP_FWD,   16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 11'd0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]  cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_operation = '0;
  logic [NW-1:0]       in_source = '0;
  logic [NW-1:0]       in_destination = '0;
  logic [TW-1:0]       in_timestamp = '0;
  logic [TW-1:0]       in_start_time = '0;
  logic [TW-1:0]       in_end_time = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_accepted;
  logic                out_valid_res;
  logic [NW-1:0]       out_source;
  logic [NW-1:0]       out_destination;
  logic [TW-1:0]       out_timestamp;
  logic [CNT_W-1:0]    out_match_count;

  // buffer model state and scoreboard
  packet_t             held_packets[$];
  logic [LIMIT_W-1:0]  packet_limit = LIMIT_RESET;
  op_result_t          pending_results[$];
  logic [TW-1:0]       time_base;
  int                  failures = 0;
  int                  idle_cycles = 0;
  bit                  calm = 1'b0;

  bounded_packet_fifo_with_dedup_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_source      (in_source),
    .in_destination (in_destination),
    .in_timestamp   (in_timestamp),
    .in_start_time  (in_start_time),
    .in_end_time    (in_end_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_accepted   (out_accepted),
    .out_valid_res  (out_valid_res),
    .out_source     (out_source),
    .out_destination(out_destination),
    .out_timestamp  (out_timestamp),
    .out_match_count(out_match_count)
  );

  always #4 clk = ~clk;

  // clamp the limit register to 1..DEPTH
  function automatic int unsigned active_limit();
    if (packet_limit == 0) return 1;
    if (packet_limit > DEPTH_DEF) return DEPTH_DEF;
    return packet_limit;
  endfunction

  // apply one operation to the buffer model and return its result
  function automatic op_result_t apply_packet_op(packet_op_t it);
    op_result_t res;
    packet_t    pkt;
    bit         dup;
    int unsigned hits;
    res = '{1'b0, 1'b0, '0, '0, '0, '0};
    dup = 1'b0;
    hits = 0;
    case (it.op)
      OP_ADD: begin
        foreach (held_packets[i]) begin
          if (held_packets[i].src == it.src && held_packets[i].dst == it.dst &&
              held_packets[i].ts == it.ts) dup = 1'b1;
        end
        if (!dup) begin
          // drop one oldest packet only, even when fill is above the limit
          if (held_packets.size() >= active_limit()) void'(held_packets.pop_front());
          pkt.src = it.src;
          pkt.dst = it.dst;
          pkt.ts  = it.ts;
          held_packets.insert(held_packets.size(), pkt);
          res.accepted = 1'b1;
        end
      end
      OP_FWD: begin
        if (held_packets.size() != 0) begin
          pkt = held_packets.pop_front();
          res.valid_res = 1'b1;
          res.src = pkt.src;
          res.dst = pkt.dst;
          res.ts  = pkt.ts;
        end
      end
      OP_COUNT: begin
        foreach (held_packets[i]) begin
          if (held_packets[i].dst == it.dst && held_packets[i].ts >= it.t_lo &&
              held_packets[i].ts <= it.t_hi) hits++;
        end
        res.count = hits[CNT_W-1:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  // random operation; mostly small id pools and nearby times so that
  // duplicates and count hits are common, with some fully random noise
  function automatic packet_op_t random_item(int unsigned add_pct);
    packet_op_t  it;
    int unsigned pick;
    logic [TW-1:0] swap;
    it.op   = op_t'($urandom_range(3));
    it.src  = NW'($urandom);
    it.dst  = NW'($urandom);
    it.ts   = $urandom;
    it.t_lo = $urandom;
    it.t_hi = $urandom;
    if ($urandom_range(99) < 8) return it;
    pick = $urandom_range(99);
    if (pick < add_pct) begin
      it.op = OP_ADD;
      if ($urandom_range(4) != 0) it.src = NW'($urandom_range(3));
      if ($urandom_range(4) != 0) it.dst = NW'($urandom_range(3));
      if ($urandom_range(9) != 0) it.ts = time_base + $urandom_range(3);
      time_base = time_base + $urandom_range(2);
    end else begin
      pick = $urandom_range(99);
      if (pick < 48) begin
        it.op = OP_FWD;
      end else if (pick < 95) begin
        it.op = OP_COUNT;
        if ($urandom_range(4) != 0) it.dst = NW'($urandom_range(3));
        pick = $urandom_range(9);
        if (pick == 0) begin
          it.t_lo = '0;
          it.t_hi = '1;
        end else if (pick != 1) begin
          it.t_lo = time_base - $urandom_range(8);
          it.t_hi = it.t_lo + $urandom_range(8);
          // occasionally reverse the range
          if (pick == 2) begin
            swap = it.t_lo;
            it.t_lo = it.t_hi + 1;
            it.t_hi = swap;
          end
        end
      end else begin
        it.op = OP_NOP;
      end
    end
    return it;
  endfunction

  // present one item and hold it until the block takes it
  task automatic present_item(input packet_op_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= it.op;
    in_source      <= it.src;
    in_destination <= it.dst;
    in_timestamp   <= it.ts;
    in_start_time  <= it.t_lo;
    in_end_time    <= it.t_hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drain all results, let the block settle, then write the limit
  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    packet_limit = value;
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] value, input int n,
                           input int unsigned add_pct);
    packet_op_t it;
    set_limit(value);
    repeat (n) begin
      it = random_item(add_pct);
      present_item(it);
      pending_results.insert(pending_results.size(), apply_packet_op(it));
    end
  endtask

  // result-side stall
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // check each result against the oldest expectation
  always @(posedge clk) begin : result_check
    op_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result acc=%0d vr=%0d src=%h dst=%h ts=%h cnt=%0d",
                   $realtime, out_accepted, out_valid_res, out_source, out_destination,
                   out_timestamp, out_match_count);
      end else begin
        want = pending_results.pop_front();
        if (out_accepted !== want.accepted || out_valid_res !== want.valid_res ||
            out_source !== want.src || out_destination !== want.dst ||
            out_timestamp !== want.ts || out_match_count !== want.count) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: mismatch expected acc=%0d vr=%0d src=%h dst=%h ts=%h cnt=%0d",
                     $realtime, want.accepted, want.valid_res, want.src, want.dst,
                     want.ts, want.count);
            $display("%0t:          actual   acc=%0d vr=%0d src=%h dst=%h ts=%h cnt=%0d",
                     $realtime, out_accepted, out_valid_res, out_source, out_destination,
                     out_timestamp, out_match_count);
          end
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("bounded_packet_fifo_with_dedup_core test failed");
      $finish;
    end
  end

  initial begin : stimulus
    packet_op_t it;
    op_result_t res;
    op_result_t typed;
    time_base = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at the reset limit
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      it.op   = DIRECTED_ROWS[i].op;
      it.src  = DIRECTED_ROWS[i].src;
      it.dst  = DIRECTED_ROWS[i].dst;
      it.ts   = DIRECTED_ROWS[i].ts;
      it.t_lo = DIRECTED_ROWS[i].t_lo;
      it.t_hi = DIRECTED_ROWS[i].t_hi;
      present_item(it);
      res = apply_packet_op(it);
      if (DIRECTED_ROWS[i].known) begin
        typed = '{DIRECTED_ROWS[i].want_acc, 1'b0, '0, '0, '0, DIRECTED_ROWS[i].want_cnt};
        pending_results.insert(pending_results.size(), typed);
      end else begin
        pending_results.insert(pending_results.size(), res);
      end
    end

    // random phases; a zero limit acts as one, oversize acts as the depth
    run_phase(11'd0, 60, 45);
    run_phase(11'd1, 50, 45);
    run_phase(11'd2, 60, 50);
    calm = 1'b1;
    run_phase(11'd5, 80, 50);
    calm = 1'b0;
    run_phase(11'd16, 45, 50);
    // fill up, then lower the limit below the fill level
    run_phase(11'd16, 40, 90);
    run_phase(11'd3, 60, 45);
    run_phase(11'd2047, 50, 60);
    run_phase(11'd1024, 60, 70);
    run_phase(11'd7, 50, 45);

    // drain and let the block go quiet
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("bounded_packet_fifo_with_dedup_core test passed");
    end else begin
      $display("bounded_packet_fifo_with_dedup_core test failed");
    end
    $finish;
  end

endmodule
